@@ rtl/ptb_pkg.sv @@
// ptb_pkg: shared types and constants of the palindromic tree builder
// field widths, controller state codes and the result record
// no dependencies
`default_nettype none

package ptb_pkg;

  localparam int SYM_W = 5;
  localparam int CNT_W = 13;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK1,
    S_CHILD1,
    S_CVAL1,
    S_ISSUE2,
    S_WALK2,
    S_CHILD2,
    S_CVAL2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] distinct_count;
    logic [CNT_W-1:0] suffix_length;
    logic             is_new;
    logic             overflow;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/ptb_in_if.sv @@
// ptb_in_if: input channel of the palindromic tree builder
// valid/ready handshake carrying one symbol item; uses ptb_pkg
`default_nettype none

interface ptb_in_if;
  logic                      valid;
  logic                      ready;
  logic [ptb_pkg::SYM_W-1:0] symbol;
  logic                      start_req;

  modport source (output valid, output symbol, output start_req, input ready);
  modport sink   (input valid, input symbol, input start_req, output ready);
endinterface

`default_nettype wire

@@ rtl/ptb_out_if.sv @@
// ptb_out_if: result channel of the palindromic tree builder
// valid/ready handshake carrying one result item; uses ptb_pkg
`default_nettype none

interface ptb_out_if;
  logic                      valid;
  logic                      ready;
  logic [ptb_pkg::CNT_W-1:0] distinct_count;
  logic [ptb_pkg::CNT_W-1:0] suffix_length;
  logic                      is_new;
  logic                      overflow;

  modport source (output valid, output distinct_count, output suffix_length,
                  output is_new, output overflow, input ready);
  modport sink   (input valid, input distinct_count, input suffix_length,
                  input is_new, input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/ptb_ram.sv @@
// ptb_ram: generic simple dual-port ram, one write and one read port
// read data registered, valid in the cycle after re; no dependencies
`default_nettype none

module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/ptb_ctrl.sv @@
// ptb_ctrl: sequencer of the palindromic tree builder
// walks suffix links through the node and history rams, looks up and
// creates children in the child ram; uses ptb_pkg and ptb_in_if
`default_nettype none

module ptb_ctrl #(
  parameter int MAX_LEN = 4096,
  parameter int ALPHABET = 26,
  localparam int NODE_CAP = MAX_LEN + 2,
  localparam int ID_W = $clog2(NODE_CAP),
  localparam int TOT_W = $clog2(NODE_CAP + 1),
  localparam int POS_W = $clog2(MAX_LEN + 1),
  localparam int HA_W = $clog2(MAX_LEN),
  localparam int LEN_W = POS_W,
  localparam int SL_W = LEN_W + 1,
  localparam int NR_W = LEN_W + 2 * ID_W + ptb_pkg::SYM_W,
  localparam int CHILD_DEPTH = NODE_CAP * ALPHABET,
  localparam int CA_W = $clog2(CHILD_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  ptb_in_if.sink                         in_ch,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output ptb_pkg::res_t                  res,
  output logic                           hist_we,
  output logic [HA_W-1:0]                hist_waddr,
  output logic [ptb_pkg::SYM_W-1:0]      hist_wdata,
  output logic                           hist_re,
  output logic [HA_W-1:0]                hist_raddr,
  input  wire logic [ptb_pkg::SYM_W-1:0] hist_rdata,
  output logic                           node_we,
  output logic [ID_W-1:0]                node_waddr,
  output logic [NR_W-1:0]                node_wdata,
  output logic                           node_re,
  output logic [ID_W-1:0]                node_raddr,
  input  wire logic [NR_W-1:0]           node_rdata,
  output logic                           child_we,
  output logic [CA_W-1:0]                child_waddr,
  output logic [ID_W-1:0]                child_wdata,
  output logic                           child_re,
  output logic [CA_W-1:0]                child_raddr,
  input  wire logic [ID_W-1:0]           child_rdata
);

  localparam int SYM_W = ptb_pkg::SYM_W;
  localparam int CNT_W = ptb_pkg::CNT_W;
  localparam int B_W = POS_W + 2;

  ptb_pkg::state_t state_r, state_nxt;

  logic [SYM_W-1:0]       sym_r, sym_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic [ID_W-1:0]        last_r, last_nxt;
  logic signed [SL_W-1:0] last_len_r, last_len_nxt;
  logic [ID_W-1:0]        last_link_r, last_link_nxt;
  logic [ID_W-1:0]        wk_node_r, wk_node_nxt;
  logic signed [SL_W-1:0] wk_len_r, wk_len_nxt;
  logic [ID_W-1:0]        wk_link_r, wk_link_nxt;
  logic                   bok_r, bok_nxt;
  logic [ID_W-1:0]        u_r, u_nxt;
  logic signed [SL_W-1:0] u_len_r, u_len_nxt;
  logic [ID_W-1:0]        u_link_r, u_link_nxt;
  ptb_pkg::res_t          res_r, res_nxt;

  // fields of a node record
  logic [LEN_W-1:0]       nd_len;
  logic [ID_W-1:0]        nd_link;
  logic [ID_W-1:0]        nd_par;
  logic [SYM_W-1:0]       nd_sym;

  logic [ID_W-1:0]        nx_sel;
  logic signed [SL_W-1:0] nx_len;
  logic [ID_W-1:0]        nx_link;
  logic [ID_W-1:0]        an;
  logic [CA_W-1:0]        chaddr;
  logic                   c_ok;
  logic                   match;
  logic [LEN_W-1:0]       new_len;
  logic [ID_W-1:0]        link_v;
  logic [ID_W-1:0]        v_id;
  logic [B_W-1:0]         pre_pos;
  logic                   issue;
  logic [SYM_W-1:0]       sym_sat;

  assign nd_len  = node_rdata[NR_W-1 -: LEN_W];
  assign nd_link = node_rdata[NR_W-LEN_W-1 -: ID_W];
  assign nd_par  = node_rdata[SYM_W +: ID_W];
  assign nd_sym  = node_rdata[SYM_W-1:0];

  // roots are constants, other nodes come from the node ram read
  always_comb begin
    nx_sel = (state_r == ptb_pkg::S_ISSUE2) ? u_link_r : wk_link_r;
    if (nx_sel == ID_W'(0)) begin
      nx_len  = '0;
      nx_link = ID_W'(1);
    end else if (nx_sel == ID_W'(1)) begin
      nx_len  = '1;
      nx_link = '0;
    end else begin
      nx_len  = {1'b0, nd_len};
      nx_link = nd_link;
    end
  end

  // a stale child entry counts only if the node it names was made here
  always_comb begin
    c_ok = 1'b0;
    if (child_rdata >= ID_W'(2) && TOT_W'(child_rdata) < total_r) begin
      if (nd_par == wk_node_r && nd_sym == sym_r) begin
        c_ok = 1'b1;
      end
    end
  end

  assign an      = (state_r == ptb_pkg::S_CVAL2) ? u_r : wk_node_r;
  assign chaddr  = CA_W'(an) * CA_W'(ALPHABET) + CA_W'(sym_r);
  assign match   = (wk_node_r == ID_W'(1)) || (bok_r && hist_rdata == sym_r);
  assign new_len = LEN_W'(u_len_r + SL_W'(2));
  assign link_v  = c_ok ? child_rdata : '0;
  assign v_id    = ID_W'(total_r);
  assign sym_sat = (int'(in_ch.symbol) >= ALPHABET) ? SYM_W'(ALPHABET - 1)
                                                     : in_ch.symbol;

  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    last_nxt      = last_r;
    last_len_nxt  = last_len_r;
    last_link_nxt = last_link_r;
    wk_node_nxt   = wk_node_r;
    wk_len_nxt    = wk_len_r;
    wk_link_nxt   = wk_link_r;
    u_nxt         = u_r;
    u_len_nxt     = u_len_r;
    u_link_nxt    = u_link_r;
    res_nxt       = res_r;
    issue         = 1'b0;
    in_ch.ready   = 1'b0;
    res_valid     = 1'b0;
    hist_we       = 1'b0;
    hist_waddr    = '0;
    hist_wdata    = sym_sat;
    node_we       = 1'b0;
    node_waddr    = v_id;
    node_wdata    = {new_len, link_v, u_r, sym_r};
    node_re       = 1'b0;
    node_raddr    = child_rdata;
    child_we      = 1'b0;
    child_waddr   = chaddr;
    child_wdata   = v_id;
    child_re      = 1'b0;
    child_raddr   = chaddr;

    case (state_r)
      ptb_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          sym_nxt = sym_sat;
          if (in_ch.start_req) begin
            total_nxt     = TOT_W'(2);
            last_nxt      = '0;
            last_len_nxt  = '0;
            last_link_nxt = ID_W'(1);
            pos_nxt       = '0;
          end
          if (!in_ch.start_req && pos_r >= POS_W'(MAX_LEN)) begin
            res_nxt.distinct_count = CNT_W'(total_r - TOT_W'(2));
            res_nxt.suffix_length  = '0;
            res_nxt.is_new         = 1'b0;
            res_nxt.overflow       = 1'b1;
            state_nxt              = ptb_pkg::S_OUT;
          end else begin
            hist_we     = 1'b1;
            hist_waddr  = pos_nxt[HA_W-1:0];
            wk_node_nxt = last_nxt;
            wk_len_nxt  = last_len_nxt;
            wk_link_nxt = last_link_nxt;
            issue       = 1'b1;
            state_nxt   = ptb_pkg::S_WALK1;
          end
        end
      end

      ptb_pkg::S_WALK1,
      ptb_pkg::S_WALK2: begin
        if (match) begin
          child_re = 1'b1;
          if (state_r == ptb_pkg::S_WALK1) begin
            u_nxt      = wk_node_r;
            u_len_nxt  = wk_len_r;
            u_link_nxt = wk_link_r;
            state_nxt  = ptb_pkg::S_CHILD1;
          end else begin
            state_nxt  = ptb_pkg::S_CHILD2;
          end
        end else begin
          wk_node_nxt = wk_link_r;
          wk_len_nxt  = nx_len;
          wk_link_nxt = nx_link;
          issue       = 1'b1;
        end
      end

      ptb_pkg::S_CHILD1: begin
        node_re   = 1'b1;
        state_nxt = ptb_pkg::S_CVAL1;
      end

      ptb_pkg::S_CVAL1: begin
        if (c_ok) begin
          last_nxt               = child_rdata;
          last_len_nxt           = {1'b0, nd_len};
          last_link_nxt          = nd_link;
          pos_nxt                = pos_r + POS_W'(1);
          res_nxt.distinct_count = CNT_W'(total_r - TOT_W'(2));
          res_nxt.suffix_length  = CNT_W'(nd_len);
          res_nxt.is_new         = 1'b0;
          res_nxt.overflow       = 1'b0;
          state_nxt              = ptb_pkg::S_OUT;
        end else if (total_r < TOT_W'(NODE_CAP)) begin
          node_re    = 1'b1;
          node_raddr = u_link_r;
          state_nxt  = ptb_pkg::S_ISSUE2;
        end else begin
          // node store full: no child, fall back to the empty root
          last_nxt               = '0;
          last_len_nxt           = '0;
          last_link_nxt          = ID_W'(1);
          pos_nxt                = pos_r + POS_W'(1);
          res_nxt.distinct_count = CNT_W'(total_r - TOT_W'(2));
          res_nxt.suffix_length  = '0;
          res_nxt.is_new         = 1'b0;
          res_nxt.overflow       = 1'b0;
          state_nxt              = ptb_pkg::S_OUT;
        end
      end

      ptb_pkg::S_ISSUE2: begin
        wk_node_nxt = u_link_r;
        wk_len_nxt  = nx_len;
        wk_link_nxt = nx_link;
        issue       = 1'b1;
        state_nxt   = ptb_pkg::S_WALK2;
      end

      ptb_pkg::S_CHILD2: begin
        node_re   = 1'b1;
        state_nxt = ptb_pkg::S_CVAL2;
      end

      ptb_pkg::S_CVAL2: begin
        node_we                = 1'b1;
        child_we               = 1'b1;
        total_nxt              = total_r + TOT_W'(1);
        last_nxt               = v_id;
        last_len_nxt           = {1'b0, new_len};
        last_link_nxt          = link_v;
        pos_nxt                = pos_r + POS_W'(1);
        res_nxt.distinct_count = CNT_W'(total_r - TOT_W'(1));
        res_nxt.suffix_length  = CNT_W'(new_len);
        res_nxt.is_new         = 1'b1;
        res_nxt.overflow       = 1'b0;
        state_nxt              = ptb_pkg::S_OUT;
      end

      ptb_pkg::S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ptb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ptb_pkg::S_IDLE;
      end
    endcase

    // start one walk step: history byte before the palindrome, next link
    pre_pos = {2'b00, pos_nxt} - {wk_len_nxt[SL_W-1], wk_len_nxt} - B_W'(1);
    bok_nxt = bok_r;
    hist_re = 1'b0;
    hist_raddr = pre_pos[HA_W-1:0];
    if (issue) begin
      bok_nxt    = !pre_pos[B_W-1];
      hist_re    = 1'b1;
      node_re    = 1'b1;
      node_raddr = wk_link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptb_pkg::S_IDLE;
      pos_r       <= '0;
      total_r     <= TOT_W'(2);
      last_r      <= '0;
      last_len_r  <= '0;
      last_link_r <= ID_W'(1);
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      last_r      <= last_nxt;
      last_len_r  <= last_len_nxt;
      last_link_r <= last_link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r     <= sym_nxt;
    wk_node_r <= wk_node_nxt;
    wk_len_r  <= wk_len_nxt;
    wk_link_r <= wk_link_nxt;
    bok_r     <= bok_nxt;
    u_r       <= u_nxt;
    u_len_r   <= u_len_nxt;
    u_link_r  <= u_link_nxt;
    res_r     <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

@@ rtl/palindromic_tree_builder.sv @@
// palindromic_tree_builder: online eertree over a stream of letters, one result per item
// per item: accept, first suffix-link walk, child read and check; if the child exists
//   the result follows, else a second walk, child read and node write; an item past
//   MAX_LEN skips the walks; the next item is accepted only after the result is taken
// in each walk one suffix link is followed per cycle, read from node and history rams
// reset: synchronous active low, tree empty at once, no ram clearing pass
`default_nettype none

module palindromic_tree_builder #(
  parameter int MAX_LEN = 4096,
  parameter int ALPHABET = 26,
  localparam int NODE_CAP = MAX_LEN + 2,
  localparam int ID_W = $clog2(NODE_CAP),
  localparam int POS_W = $clog2(MAX_LEN + 1),
  localparam int HA_W = $clog2(MAX_LEN),
  localparam int LEN_W = POS_W,
  localparam int NR_W = LEN_W + 2 * ID_W + ptb_pkg::SYM_W,
  localparam int CHILD_DEPTH = NODE_CAP * ALPHABET,
  localparam int CA_W = $clog2(CHILD_DEPTH)
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ptb_in_if.sink     in_ch,
  ptb_out_if.source  out_ch
);

  logic                      res_valid;
  logic                      res_ready;
  ptb_pkg::res_t             res;

  logic                      hist_we, hist_re;
  logic [HA_W-1:0]           hist_waddr, hist_raddr;
  logic [ptb_pkg::SYM_W-1:0] hist_wdata, hist_rdata;
  logic                      node_we, node_re;
  logic [ID_W-1:0]           node_waddr, node_raddr;
  logic [NR_W-1:0]           node_wdata, node_rdata;
  logic                      child_we, child_re;
  logic [CA_W-1:0]           child_waddr, child_raddr;
  logic [ID_W-1:0]           child_wdata, child_rdata;

  logic                      out_valid_r, out_valid_nxt;
  ptb_pkg::res_t             out_res_r;

  ptb_ctrl #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .hist_we     (hist_we),
    .hist_waddr  (hist_waddr),
    .hist_wdata  (hist_wdata),
    .hist_re     (hist_re),
    .hist_raddr  (hist_raddr),
    .hist_rdata  (hist_rdata),
    .node_we     (node_we),
    .node_waddr  (node_waddr),
    .node_wdata  (node_wdata),
    .node_re     (node_re),
    .node_raddr  (node_raddr),
    .node_rdata  (node_rdata),
    .child_we    (child_we),
    .child_waddr (child_waddr),
    .child_wdata (child_wdata),
    .child_re    (child_re),
    .child_raddr (child_raddr),
    .child_rdata (child_rdata)
  );

  ptb_ram #(.WIDTH(ptb_pkg::SYM_W), .DEPTH(MAX_LEN)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // per node: length, suffix link, parent and symbol of its edge
  ptb_ram #(.WIDTH(NR_W), .DEPTH(NODE_CAP)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  ptb_ram #(.WIDTH(ID_W), .DEPTH(CHILD_DEPTH)) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .re    (child_re),
    .raddr (child_raddr),
    .rdata (child_rdata)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.distinct_count = out_res_r.distinct_count;
  assign out_ch.suffix_length  = out_res_r.suffix_length;
  assign out_ch.is_new         = out_res_r.is_new;
  assign out_ch.overflow       = out_res_r.overflow;

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken again before the item finished");

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ch.ready)
    else $error("input ready while a result is pending in the sequencer");

  a_overflow_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.overflow |-> out_res_r.suffix_length == '0 && !out_res_r.is_new)
    else $error("ignored item reports a node or a suffix length");

endmodule

`default_nettype wire
